// ----- sv/asfe_pkg.sv -----
// Shared constants, item types and sequencer states of the adaptive Shannon-Fano encoder.
`timescale 1ns / 1ps
package asfe_pkg;

  localparam int MAX_CODE_BITS = 16;
  localparam int COUNT_BITS    = 24;
  localparam int NSYM          = 258;
  localparam int SYM_W         = 9;
  localparam int MAX_OUT       = 4;
  localparam int ACC_BITS      = 64;
  localparam int ACC_CNT_W     = $clog2(ACC_BITS + 1);
  localparam int ACC_IDX_W     = $clog2(ACC_BITS);
  localparam int LEN_W         = $clog2(MAX_CODE_BITS + 2);
  localparam int CODE_IDX_W    = $clog2(MAX_CODE_BITS);
  localparam int SUM_W         = COUNT_BITS + SYM_W;
  localparam int PASS_LIMIT    = 80;
  localparam int PASS_W        = $clog2(PASS_LIMIT + 1);
  localparam int OUT_CNT_W     = $clog2(MAX_OUT + 1);
  localparam int SEG_W         = 2 * SYM_W;
  localparam int PCODE_W       = LEN_W + MAX_CODE_BITS;

  localparam logic [SYM_W-1:0]      ESC_SYM   = SYM_W'(256);
  localparam logic [SYM_W-1:0]      END_SYM   = SYM_W'(257);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic push_bit;
    logic pop;
    logic pop_last;
  } pack_ctl_t;

  typedef struct packed {
    logic [ACC_CNT_W-1:0] bit_cnt;
    logic                 out_free;
  } pack_sts_t;

  typedef enum logic [4:0] {
    S_INIT0, S_INIT1, S_IDLE, S_LK_POS, S_LK_CODE, S_PUSH, S_PAD, S_DRAIN,
    S_UPD, S_RM_POS, S_RM_RD, S_RM_WR, S_NEW_START, S_NEW_RD, S_NEW_CMP,
    S_OLD_POS, S_OLD_CNT, S_OLD_RD, S_OLD_CMP, S_PUT, S_RB_START, S_SEG,
    S_SUM, S_CUT, S_PUSHL, S_PUSHR, S_MARK, S_POP, S_HALVE
  } asfe_state_t;

endpackage

// ----- sv/asfe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module asfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/asfe_packer.sv -----
// Bit accumulator and output register that packs code bits into bytes, first bit on top.
`timescale 1ns / 1ps
module asfe_packer import asfe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  pack_ctl_t ctl,
  output pack_sts_t sts,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [ACC_BITS-1:0]  acc_r, acc_nxt;
  logic [ACC_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;
  logic [ACC_IDX_W-1:0] ptr;

  assign ptr = ACC_IDX_W'(cnt_r - ACC_CNT_W'(8));

  always_comb begin
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    // Bits past a full accumulator are dropped.
    if (ctl.push && (cnt_r < ACC_CNT_W'(ACC_BITS))) begin
      acc_nxt = {acc_r[ACC_BITS-2:0], ctl.push_bit};
      cnt_nxt = cnt_r + ACC_CNT_W'(1);
    end
    if (ctl.pop) begin
      cnt_nxt                  = cnt_r - ACC_CNT_W'(8);
      out_valid_nxt            = 1'b1;
      out_data_nxt.out_byte    = acc_r[ptr +: 8];
      out_data_nxt.last_of_run = ctl.pop_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign sts.bit_cnt  = cnt_r;
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

// ----- sv/adaptive_shannon_fano_encoder.sv -----
// Top level of the adaptive Shannon-Fano encoder: sequencer, model memories and rebuild.
//
//   channel | direction | ports                         | moves
//   in      | input     | in_valid, in_ready, in_data   | opcode and data byte
//   out     | output    | out_valid, out_ready, out_data| packed byte and last flag
//
// Coding an item runs the lookup, pushes up to 24 bits, then pads and drains.
// The list update then moves the symbol one place at a time with a read step and a write
// step per place, and it runs longest when the escape leaves and a new byte enters together.
// The rebuild costs the most: each segment streams its entries for the sum, the cut search
// and the marking, and a pass whose codes run too long adds a halving sweep and starts over.
// After reset a short setup writes the two initial list entries and builds their codes.
// A stalled output only holds the drain step; in_ready is high in the idle state alone.
`timescale 1ns / 1ps
module adaptive_shannon_fano_encoder import asfe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  asfe_state_t state_r, state_nxt;

  logic                   op_r, op_nxt;
  logic [7:0]             byte_r, byte_nxt;
  logic                   need_raw_r, need_raw_nxt;
  logic [MAX_CODE_BITS-1:0] code_r, code_nxt;
  logic [LEN_W-1:0]       bits_left_r, bits_left_nxt;
  logic [SYM_W-1:0]       list_len_r, list_len_nxt;
  logic [SYM_W-1:0]       distinct_r, distinct_nxt;
  logic [255:0]           seen_r, seen_nxt;
  logic [SYM_W-1:0]       pos_r, pos_nxt;
  logic [COUNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [SYM_W-1:0]       seg_st_r, seg_st_nxt;
  logic [SYM_W-1:0]       seg_c_r, seg_c_nxt;
  logic                   root_r, root_nxt;
  logic                   fail_r, fail_nxt;
  logic [SYM_W-1:0]       lc_r, lc_nxt;
  logic [SYM_W-1:0]       iss_r, iss_nxt;
  logic [SYM_W-1:0]       di_r, di_nxt;
  logic                   v_r, v_nxt;
  logic                   v2_r, v2_nxt;
  logic [SYM_W-1:0]       i1_r, i1_nxt;
  logic [SUM_W-1:0]       total_r, total_nxt;
  logic [SUM_W-1:0]       p_r, p_nxt;
  logic [SUM_W:0]         best_r, best_nxt;
  logic [SYM_W-1:0]       cut_r, cut_nxt;
  logic [SYM_W-1:0]       sp_r, sp_nxt;
  logic [PASS_W-1:0]      pass_r, pass_nxt;
  logic [OUT_CNT_W-1:0]   k_r, k_nxt;

  // memory ports
  logic                  rk_we, spos_we, cn_we, pc_we, st_we;
  logic [SYM_W-1:0]      rk_waddr, rk_wdata, rk_raddr, rk_rdata;
  logic [SYM_W-1:0]      spos_waddr, spos_wdata, spos_raddr, spos_rdata;
  logic [SYM_W-1:0]      cn_waddr, cn_raddr;
  logic [COUNT_BITS-1:0] cn_wdata, cn_rdata;
  logic [SYM_W-1:0]      pc_waddr, pc_raddr;
  logic [PCODE_W-1:0]    pc_wdata, pc_rdata;
  logic [SYM_W-1:0]      st_waddr, st_raddr;
  logic [SEG_W-1:0]      st_wdata, st_rdata;

  pack_ctl_t pk_ctl;
  pack_sts_t pk_sts;

  asfe_ram #(.WIDTH(SYM_W), .DEPTH(NSYM)) u_rank (
    .clk, .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata), .raddr(rk_raddr), .rdata(rk_rdata)
  );
  asfe_ram #(.WIDTH(SYM_W), .DEPTH(NSYM)) u_spos (
    .clk, .we(spos_we), .waddr(spos_waddr), .wdata(spos_wdata), .raddr(spos_raddr),
    .rdata(spos_rdata)
  );
  asfe_ram #(.WIDTH(COUNT_BITS), .DEPTH(NSYM)) u_count (
    .clk, .we(cn_we), .waddr(cn_waddr), .wdata(cn_wdata), .raddr(cn_raddr), .rdata(cn_rdata)
  );
  asfe_ram #(.WIDTH(PCODE_W), .DEPTH(NSYM)) u_code (
    .clk, .we(pc_we), .waddr(pc_waddr), .wdata(pc_wdata), .raddr(pc_raddr), .rdata(pc_rdata)
  );
  asfe_ram #(.WIDTH(SEG_W), .DEPTH(NSYM)) u_stack (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata), .raddr(st_raddr), .rdata(st_rdata)
  );

  asfe_packer u_packer (
    .clk, .rst_n, .ctl(pk_ctl), .sts(pk_sts), .out_valid, .out_ready, .out_data
  );

  // shared helpers
  logic [SYM_W-1:0]  lk_sym, strm_addr, wr_addr, strm_len, rc;
  logic              strm_issue, strm_done;
  logic              pos_next_ok, more, in_seen;
  logic [SUM_W:0]    tot_ext, twice, half_err;
  logic              mark_bit;
  logic [LEN_W-1:0]  old_len, new_len;
  logic [MAX_CODE_BITS-1:0] old_code, new_code;

  assign in_seen   = seen_r[in_data.data_byte];
  assign lk_sym    = (in_data.opcode == OP_FLUSH) ? END_SYM :
                     (in_seen ? {1'b0, in_data.data_byte} : ESC_SYM);
  assign strm_addr = seg_st_r + iss_r;
  assign wr_addr   = seg_st_r + di_r;
  assign rc        = seg_c_r - lc_r;
  assign pos_next_ok = ({1'b0, pos_r} + (SYM_W+1)'(1)) < {1'b0, list_len_r};
  assign more = (pk_sts.bit_cnt >= ACC_CNT_W'(8)) && (k_r < OUT_CNT_W'(MAX_OUT));

  always_comb begin
    case (state_r)
      S_SUM, S_MARK: strm_len = seg_c_r;
      S_CUT:         strm_len = seg_c_r - SYM_W'(1);
      S_HALVE:       strm_len = list_len_r;
      default:       strm_len = '0;
    endcase
  end
  assign strm_issue = iss_r < strm_len;
  assign strm_done  = !strm_issue && !v_r && !v2_r;

  assign tot_ext  = {1'b0, total_r};
  assign twice    = {p_r, 1'b0};
  assign half_err = (tot_ext >= twice) ? (tot_ext - twice) : (twice - tot_ext);

  assign mark_bit = di_r < lc_r;
  assign old_len  = pc_rdata[PCODE_W-1:MAX_CODE_BITS];
  assign old_code = pc_rdata[MAX_CODE_BITS-1:0];
  assign new_len  = root_r ? LEN_W'(1) : (old_len + LEN_W'(1));
  assign new_code = root_r ? MAX_CODE_BITS'(mark_bit) : {old_code[MAX_CODE_BITS-2:0], mark_bit};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT0:   state_nxt = S_INIT1;
      S_INIT1:   state_nxt = S_RB_START;
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.opcode == OP_ENCODE && !in_seen && distinct_r == '0) begin
            state_nxt = S_PUSH;
          end else begin
            state_nxt = S_LK_POS;
          end
        end
      end
      S_LK_POS:  state_nxt = S_LK_CODE;
      S_LK_CODE: state_nxt = S_PUSH;
      S_PUSH: begin
        if (bits_left_r == '0 && !need_raw_r) begin
          state_nxt = (op_r == OP_FLUSH) ? S_PAD : S_DRAIN;
        end
      end
      S_PAD:     if (pk_sts.bit_cnt[2:0] == 3'd0) state_nxt = S_DRAIN;
      S_DRAIN:   if (!more) state_nxt = (op_r == OP_FLUSH) ? S_IDLE : S_UPD;
      S_UPD: begin
        if (seen_r[byte_r]) begin
          state_nxt = S_OLD_POS;
        end else if ((distinct_r + SYM_W'(1)) >= SYM_W'(256) && list_len_r > SYM_W'(1)) begin
          state_nxt = S_RM_POS;
        end else begin
          state_nxt = S_NEW_START;
        end
      end
      S_RM_POS:  state_nxt = S_RM_RD;
      S_RM_RD:   state_nxt = pos_next_ok ? S_RM_WR : S_NEW_START;
      S_RM_WR:   state_nxt = S_RM_RD;
      S_NEW_START: state_nxt = (list_len_r >= SYM_W'(NSYM)) ? S_RB_START : S_NEW_RD;
      S_NEW_RD:  state_nxt = (pos_r > SYM_W'(1)) ? S_NEW_CMP : S_PUT;
      S_NEW_CMP: state_nxt = (cn_rdata > cnt_r) ? S_NEW_RD : S_PUT;
      S_OLD_POS: state_nxt = S_OLD_CNT;
      S_OLD_CNT: state_nxt = S_OLD_RD;
      S_OLD_RD:  state_nxt = pos_next_ok ? S_OLD_CMP : S_PUT;
      S_OLD_CMP: state_nxt = (cnt_r > cn_rdata) ? S_OLD_RD : S_PUT;
      S_PUT:     state_nxt = S_RB_START;
      S_RB_START: state_nxt = (list_len_r >= SYM_W'(2)) ? S_SEG : S_IDLE;
      S_SEG:     state_nxt = (seg_c_r > SYM_W'(2)) ? S_SUM : S_PUSHL;
      S_SUM:     if (strm_done) state_nxt = S_CUT;
      S_CUT:     if (strm_done) state_nxt = S_PUSHL;
      S_PUSHL:   state_nxt = S_PUSHR;
      S_PUSHR:   state_nxt = S_MARK;
      S_MARK: begin
        if (strm_done) begin
          if (fail_r) begin
            state_nxt = S_HALVE;
          end else if (sp_r != '0) begin
            state_nxt = S_POP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_POP:     state_nxt = S_SEG;
      S_HALVE: begin
        if (strm_done) begin
          state_nxt = ((pass_r + PASS_W'(1)) == PASS_W'(PASS_LIMIT)) ? S_IDLE : S_RB_START;
        end
      end
      default:   state_nxt = S_INIT0;
    endcase
  end

  // outputs: handshake, memory ports and packer control
  always_comb begin
    in_ready   = 1'b0;
    rk_we = 1'b0; rk_waddr = '0; rk_wdata = '0; rk_raddr = '0;
    spos_we = 1'b0; spos_waddr = '0; spos_wdata = '0; spos_raddr = '0;
    cn_we = 1'b0; cn_waddr = '0; cn_wdata = '0; cn_raddr = '0;
    pc_we = 1'b0; pc_waddr = '0; pc_wdata = '0; pc_raddr = '0;
    st_we = 1'b0; st_waddr = sp_r; st_wdata = '0; st_raddr = sp_r - SYM_W'(1);
    pk_ctl = '0;
    case (state_r)
      S_INIT0: begin
        rk_we = 1'b1; rk_waddr = SYM_W'(0); rk_wdata = ESC_SYM;
        cn_we = 1'b1; cn_waddr = SYM_W'(0); cn_wdata = COUNT_BITS'(1);
        spos_we = 1'b1; spos_waddr = ESC_SYM; spos_wdata = SYM_W'(0);
      end
      S_INIT1: begin
        rk_we = 1'b1; rk_waddr = SYM_W'(1); rk_wdata = END_SYM;
        cn_we = 1'b1; cn_waddr = SYM_W'(1); cn_wdata = COUNT_BITS'(1);
        spos_we = 1'b1; spos_waddr = END_SYM; spos_wdata = SYM_W'(1);
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        spos_raddr = lk_sym;
      end
      S_LK_POS:  pc_raddr = spos_rdata;
      S_PUSH: begin
        if (bits_left_r != '0) begin
          pk_ctl.push     = 1'b1;
          pk_ctl.push_bit = code_r[CODE_IDX_W'(bits_left_r - LEN_W'(1))];
        end
      end
      S_PAD:     pk_ctl.push = (pk_sts.bit_cnt[2:0] != 3'd0);
      S_DRAIN: begin
        pk_ctl.pop      = more && pk_sts.out_free;
        pk_ctl.pop_last = (pk_sts.bit_cnt < ACC_CNT_W'(16)) ||
                          ((k_r + OUT_CNT_W'(1)) == OUT_CNT_W'(MAX_OUT));
      end
      S_UPD:     spos_raddr = seen_r[byte_r] ? {1'b0, byte_r} : ESC_SYM;
      S_RM_RD, S_OLD_RD: begin
        rk_raddr = pos_r + SYM_W'(1);
        cn_raddr = pos_r + SYM_W'(1);
      end
      S_NEW_RD: begin
        rk_raddr = pos_r - SYM_W'(1);
        cn_raddr = pos_r - SYM_W'(1);
      end
      S_RM_WR, S_NEW_CMP, S_OLD_CMP: begin
        // Slide the neighbor into the hole; the moving symbol lands at the end.
        if (state_r == S_RM_WR || (state_r == S_NEW_CMP && cn_rdata > cnt_r) ||
            (state_r == S_OLD_CMP && cnt_r > cn_rdata)) begin
          rk_we = 1'b1; rk_waddr = pos_r; rk_wdata = rk_rdata;
          cn_we = 1'b1; cn_waddr = pos_r; cn_wdata = cn_rdata;
          spos_we = 1'b1; spos_waddr = rk_rdata; spos_wdata = pos_r;
        end
      end
      S_OLD_POS: cn_raddr = spos_rdata;
      S_PUT: begin
        rk_we = 1'b1; rk_waddr = pos_r; rk_wdata = {1'b0, byte_r};
        cn_we = 1'b1; cn_waddr = pos_r; cn_wdata = cnt_r;
        spos_we = 1'b1; spos_waddr = {1'b0, byte_r}; spos_wdata = pos_r;
      end
      S_SUM, S_CUT: cn_raddr = strm_addr;
      S_PUSHL: begin
        st_we    = (lc_r > SYM_W'(1)) && (sp_r < SYM_W'(NSYM));
        st_wdata = {seg_st_r, lc_r};
      end
      S_PUSHR: begin
        st_we    = (rc > SYM_W'(1)) && (sp_r < SYM_W'(NSYM));
        st_wdata = {seg_st_r + lc_r, rc};
      end
      S_MARK: begin
        pc_raddr = strm_addr;
        pc_we    = v_r;
        pc_waddr = wr_addr;
        pc_wdata = {new_len, new_code};
      end
      S_HALVE: begin
        cn_raddr = iss_r;
        cn_we    = v_r;
        cn_waddr = di_r;
        cn_wdata = (cn_rdata >> 1) | COUNT_BITS'(1);
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    op_nxt = op_r; byte_nxt = byte_r; need_raw_nxt = need_raw_r;
    code_nxt = code_r; bits_left_nxt = bits_left_r;
    list_len_nxt = list_len_r; distinct_nxt = distinct_r; seen_nxt = seen_r;
    pos_nxt = pos_r; cnt_nxt = cnt_r;
    seg_st_nxt = seg_st_r; seg_c_nxt = seg_c_r; root_nxt = root_r; fail_nxt = fail_r;
    lc_nxt = lc_r; total_nxt = total_r; p_nxt = p_r; best_nxt = best_r; cut_nxt = cut_r;
    sp_nxt = sp_r; pass_nxt = pass_r; k_nxt = k_r; i1_nxt = i1_r;
    iss_nxt = iss_r; di_nxt = di_r; v_nxt = 1'b0; v2_nxt = 1'b0;

    if (state_r == S_SUM || state_r == S_CUT || state_r == S_MARK || state_r == S_HALVE) begin
      v_nxt   = strm_issue;
      iss_nxt = iss_r + SYM_W'(strm_issue);
      if (v_r) di_nxt = di_r + SYM_W'(1);
    end

    case (state_r)
      S_INIT1: begin
        list_len_nxt = SYM_W'(2);
        pass_nxt     = '0;
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_data.opcode;
          byte_nxt = in_data.data_byte;
          k_nxt    = '0;
          need_raw_nxt = (in_data.opcode == OP_ENCODE) && !in_seen;
          if (in_data.opcode == OP_ENCODE && !in_seen && distinct_r == '0) begin
            // The very first byte goes out raw with no escape.
            need_raw_nxt  = 1'b0;
            code_nxt      = {{(MAX_CODE_BITS-8){1'b0}}, in_data.data_byte};
            bits_left_nxt = LEN_W'(8);
          end
        end
      end
      S_LK_CODE: begin
        code_nxt      = old_code;
        bits_left_nxt = old_len;
      end
      S_PUSH: begin
        if (bits_left_r != '0) begin
          bits_left_nxt = bits_left_r - LEN_W'(1);
        end else if (need_raw_r) begin
          need_raw_nxt  = 1'b0;
          code_nxt      = {{(MAX_CODE_BITS-8){1'b0}}, byte_r};
          bits_left_nxt = LEN_W'(8);
        end
      end
      S_DRAIN:   if (more && pk_sts.out_free) k_nxt = k_r + OUT_CNT_W'(1);
      S_UPD: begin
        if (!seen_r[byte_r]) begin
          seen_nxt[byte_r] = 1'b1;
          distinct_nxt     = distinct_r + SYM_W'(1);
        end
      end
      S_RM_POS:  pos_nxt = spos_rdata;
      S_RM_RD:   if (!pos_next_ok) list_len_nxt = list_len_r - SYM_W'(1);
      S_RM_WR:   pos_nxt = pos_r + SYM_W'(1);
      S_NEW_START: begin
        pass_nxt = '0;
        if (list_len_r < SYM_W'(NSYM)) begin
          pos_nxt      = list_len_r;
          list_len_nxt = list_len_r + SYM_W'(1);
          cnt_nxt      = COUNT_BITS'(1);
        end
      end
      S_NEW_CMP: if (cn_rdata > cnt_r) pos_nxt = pos_r - SYM_W'(1);
      S_OLD_POS: pos_nxt = spos_rdata;
      S_OLD_CNT: cnt_nxt = (cn_rdata == COUNT_MAX) ? cn_rdata : (cn_rdata + COUNT_BITS'(1));
      S_OLD_CMP: if (cnt_r > cn_rdata) pos_nxt = pos_r + SYM_W'(1);
      S_PUT:     pass_nxt = '0;
      S_RB_START: begin
        seg_st_nxt = '0;
        seg_c_nxt  = list_len_r;
        root_nxt   = 1'b1;
        fail_nxt   = 1'b0;
        sp_nxt     = '0;
      end
      S_SEG: begin
        iss_nxt = '0; di_nxt = '0; total_nxt = '0; p_nxt = '0;
        if (seg_c_r <= SYM_W'(2)) lc_nxt = SYM_W'(1);
      end
      S_SUM: begin
        if (v_r) total_nxt = total_r + SUM_W'(cn_rdata);
        if (strm_done) begin
          iss_nxt = '0; di_nxt = '0;
        end
      end
      S_CUT: begin
        if (v_r) begin
          p_nxt  = p_r + SUM_W'(cn_rdata);
          i1_nxt = di_r;
          v2_nxt = 1'b1;
        end
        // Ties move the cut later, so the last nearest-half position wins.
        if (v2_r && (i1_r == '0 || half_err <= best_r)) begin
          best_nxt = half_err;
          cut_nxt  = i1_r;
        end
        if (strm_done) lc_nxt = cut_r + SYM_W'(1);
      end
      S_PUSHL:   if (lc_r > SYM_W'(1) && sp_r < SYM_W'(NSYM)) sp_nxt = sp_r + SYM_W'(1);
      S_PUSHR: begin
        if (rc > SYM_W'(1) && sp_r < SYM_W'(NSYM)) sp_nxt = sp_r + SYM_W'(1);
        iss_nxt = '0; di_nxt = '0;
      end
      S_MARK: begin
        if (v_r && new_len > LEN_W'(MAX_CODE_BITS)) fail_nxt = 1'b1;
        if (strm_done) begin
          iss_nxt = '0; di_nxt = '0;
          if (!fail_r && sp_r != '0) sp_nxt = sp_r - SYM_W'(1);
        end
      end
      S_POP: begin
        seg_st_nxt = st_rdata[SEG_W-1:SYM_W];
        seg_c_nxt  = st_rdata[SYM_W-1:0];
        root_nxt   = 1'b0;
      end
      S_HALVE:   if (strm_done) pass_nxt = pass_r + PASS_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT0;
      list_len_r <= SYM_W'(2);
      distinct_r <= '0;
      seen_r     <= '0;
      sp_r       <= '0;
      pass_r     <= '0;
      k_r        <= '0;
      v_r        <= 1'b0;
      v2_r       <= 1'b0;
      need_raw_r <= 1'b0;
      fail_r     <= 1'b0;
      root_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      list_len_r <= list_len_nxt;
      distinct_r <= distinct_nxt;
      seen_r     <= seen_nxt;
      sp_r       <= sp_nxt;
      pass_r     <= pass_nxt;
      k_r        <= k_nxt;
      v_r        <= v_nxt;
      v2_r       <= v2_nxt;
      need_raw_r <= need_raw_nxt;
      fail_r     <= fail_nxt;
      root_r     <= root_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    byte_r      <= byte_nxt;
    code_r      <= code_nxt;
    bits_left_r <= bits_left_nxt;
    pos_r       <= pos_nxt;
    cnt_r       <= cnt_nxt;
    seg_st_r    <= seg_st_nxt;
    seg_c_r     <= seg_c_nxt;
    lc_r        <= lc_nxt;
    iss_r       <= iss_nxt;
    di_r        <= di_nxt;
    i1_r        <= i1_nxt;
    total_r     <= total_nxt;
    p_r         <= p_nxt;
    best_r      <= best_nxt;
    cut_r       <= cut_nxt;
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while the previous item was still in work");

  a_pop_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    pk_ctl.pop |-> (pk_sts.bit_cnt >= ACC_CNT_W'(8)) && pk_sts.out_free)
    else $error("byte taken from the packer without eight bits or a free output");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SYM_W'(NSYM))
    else $error("segment stack pointer beyond its depth");

  a_mark_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK) && v_r |-> ({1'b0, wr_addr} < {1'b0, list_len_r}))
    else $error("code write outside the listed positions");
`endif

endmodule
